[design/kvd_pkg.sv]
`default_nettype none

package kvd_pkg;

   // Bytes in each big-endian length field
   localparam int unsigned LENGTH_BYTES = 4;

   localparam int unsigned CSR_INDEX_WIDTH = 3;

   typedef enum logic [2:0] {
      PH_OPCODE = 3'd0,
      PH_KEYLEN = 3'd1,
      PH_KEY    = 3'd2,
      PH_VALLEN = 3'd3,
      PH_VALUE  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      CMD_PUT   = 3'd0,
      CMD_GET   = 3'd1,
      CMD_DEL   = 3'd2,
      CMD_TAKE  = 3'd3,
      CMD_STATS = 3'd4
   } cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_OP_PUT   = 3'd0,
      CSR_OP_DEL   = 3'd1,
      CSR_OP_GET   = 3'd2,
      CSR_OP_TAKE  = 3'd3,
      CSR_OP_STATS = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0] op_put;
      logic [7:0] op_del;
      logic [7:0] op_get;
      logic [7:0] op_take;
      logic [7:0] op_stats;
   } opcodes_type;

   typedef struct packed {
      logic [2:0]  field_kind;
      logic [7:0]  data_byte;
      logic [2:0]  command;
      logic        command_done;
      logic [31:0] key_len_out;
      logic [31:0] value_len_out;
      logic        error;
   } result_type;

endpackage

`default_nettype wire

[design/kv_command_deframer.sv]
`default_nettype none
// Channel  Ports                      Direction  Moves
// req      req_valid/ready, in_byte   in         one stream byte per transaction
// rsp      rsp_valid/ready, fields    out        one tagged result per byte
// csr      csr_valid/ready, index     in         one opcode register write
//
// One byte per cycle sustained while rsp is ready; an accepted byte is held in the
// input register, then loaded into the result register, which drives rsp.
// The parser state updates once per byte as it moves into the result register.
// Reset clears the parser to the opcode phase and loads default opcodes.
// A stalled rsp holds the result; req still takes one more byte into the
// input register, then stalls.

module kv_command_deframer import kvd_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic [7:0]                 req_in_byte,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic [2:0]                 rsp_field_kind,
   output      logic [7:0]                 rsp_data_byte,
   output      logic [2:0]                 rsp_command,
   output      logic                       rsp_command_done,
   output      logic [31:0]                rsp_key_len_out,
   output      logic [31:0]                rsp_value_len_out,
   output      logic                       rsp_error,
   input  wire logic                       csr_valid,
   output      logic                       csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [7:0]                 csr_data
);

   opcodes_type opcodes;
   result_type  result;
   result_type  out_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   logic       advance;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   kvd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .opcodes   (opcodes)
   );

   kvd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_byte (in_byte_ff),
      .opcodes (opcodes),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_in_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) out_ff <= result;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_field_kind    = out_ff.field_kind;
   assign rsp_data_byte     = out_ff.data_byte;
   assign rsp_command       = out_ff.command;
   assign rsp_command_done  = out_ff.command_done;
   assign rsp_key_len_out   = out_ff.key_len_out;
   assign rsp_value_len_out = out_ff.value_len_out;
   assign rsp_error         = out_ff.error;

`ifndef SYNTHESIS
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_field_kind == PH_OPCODE && rsp_command == CMD_PUT
         && !rsp_command_done && rsp_key_len_out == '0 && rsp_value_len_out == '0)
      else $error("error result carries command state");

   a_vlen_early: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_field_kind == PH_OPCODE || rsp_field_kind == PH_KEYLEN
         || rsp_field_kind == PH_KEY) |-> rsp_value_len_out == '0)
      else $error("value length set before value length field");

   a_value_put_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_field_kind == PH_VALLEN || rsp_field_kind == PH_VALUE)
         |-> rsp_command == CMD_PUT)
      else $error("value field outside a put command");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire

[design/kvd_csr.sv]
`default_nettype none

module kvd_csr import kvd_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [7:0]                 csr_data,
   output opcodes_type                     opcodes
);

   opcodes_type opcodes_ff;
   opcodes_type opcodes_in;

   always_comb begin
      opcodes_in = opcodes_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_OP_PUT:   opcodes_in.op_put   = csr_data;
            CSR_OP_DEL:   opcodes_in.op_del   = csr_data;
            CSR_OP_GET:   opcodes_in.op_get   = csr_data;
            CSR_OP_TAKE:  opcodes_in.op_take  = csr_data;
            CSR_OP_STATS: opcodes_in.op_stats = csr_data;
            default:      opcodes_in = opcodes_ff; // drop writes beyond the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opcodes_ff.op_put   <= 8'd11;
         opcodes_ff.op_del   <= 8'd12;
         opcodes_ff.op_get   <= 8'd13;
         opcodes_ff.op_take  <= 8'd14;
         opcodes_ff.op_stats <= 8'd21;
      end else begin
         opcodes_ff <= opcodes_in;
      end
   end

   assign opcodes = opcodes_ff;

endmodule

`default_nettype wire

[design/kvd_parser.sv]
`default_nettype none

module kvd_parser import kvd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic [7:0]  in_byte,
   input  wire opcodes_type opcodes,
   output result_type       result
);

   phase_type   phase_ff,  phase_in;
   cmd_type     cmd_ff,    cmd_in;
   logic [31:0] count_ff,  count_in;
   logic [31:0] klen_ff,   klen_in;
   logic [31:0] vlen_ff,   vlen_in;

   logic [31:0] count_inc;
   logic [2:0]  kind;
   logic        done;
   logic        err;

   assign count_inc = count_ff + 32'd1;

   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      count_in = count_ff;
      klen_in  = klen_ff;
      vlen_in  = vlen_ff;
      kind     = PH_OPCODE;
      done     = 1'b0;
      err      = 1'b0;

      case (phase_ff)
         PH_KEYLEN: begin
            kind     = PH_KEYLEN;
            klen_in  = {klen_ff[23:0], in_byte};
            count_in = count_inc;
            if (count_inc >= 32'(LENGTH_BYTES)) begin
               count_in = '0;
               if (klen_in == '0) begin
                  if (cmd_ff == CMD_PUT) phase_in = PH_VALLEN;
                  else done = 1'b1;
               end else begin
                  phase_in = PH_KEY;
               end
            end
         end
         PH_KEY: begin
            kind     = PH_KEY;
            count_in = count_inc;
            if (count_inc >= klen_ff) begin
               if (cmd_ff == CMD_PUT) begin
                  phase_in = PH_VALLEN;
                  count_in = '0;
               end else begin
                  done = 1'b1;
               end
            end
         end
         PH_VALLEN: begin
            kind     = PH_VALLEN;
            vlen_in  = {vlen_ff[23:0], in_byte};
            count_in = count_inc;
            if (count_inc >= 32'(LENGTH_BYTES)) begin
               count_in = '0;
               if (vlen_in == '0) done = 1'b1;
               else phase_in = PH_VALUE;
            end
         end
         PH_VALUE: begin
            kind     = PH_VALUE;
            count_in = count_inc;
            if (count_inc >= vlen_ff) done = 1'b1;
         end
         default: begin
            // opcode phase, also for codes that mean nothing
            kind     = PH_OPCODE;
            count_in = '0;
            klen_in  = '0;
            vlen_in  = '0;
            phase_in = PH_KEYLEN;
            if (in_byte == opcodes.op_put)        cmd_in = CMD_PUT;
            else if (in_byte == opcodes.op_get)   cmd_in = CMD_GET;
            else if (in_byte == opcodes.op_del)   cmd_in = CMD_DEL;
            else if (in_byte == opcodes.op_take)  cmd_in = CMD_TAKE;
            else if (in_byte == opcodes.op_stats) cmd_in = CMD_STATS;
            else begin
               cmd_in = CMD_PUT;
               err    = 1'b1;
            end
            if (!err && cmd_in == CMD_STATS) done = 1'b1;
         end
      endcase
   end

   always_comb begin
      result.field_kind    = kind;
      result.data_byte     = in_byte;
      result.command       = cmd_in;
      result.command_done  = done;
      result.key_len_out   = klen_in;
      result.value_len_out = vlen_in;
      result.error         = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPCODE;
         cmd_ff   <= CMD_PUT;
         count_ff <= '0;
         klen_ff  <= '0;
         vlen_ff  <= '0;
      end else if (advance) begin
         if (done || err) begin
            // command finished or rejected: back to the opcode phase
            phase_ff <= PH_OPCODE;
            cmd_ff   <= CMD_PUT;
            count_ff <= '0;
            klen_ff  <= '0;
            vlen_ff  <= '0;
         end else begin
            phase_ff <= phase_in;
            cmd_ff   <= cmd_in;
            count_ff <= count_in;
            klen_ff  <= klen_in;
            vlen_ff  <= vlen_in;
         end
      end
   end

endmodule

`default_nettype wire
